// File: rtl/core/tds_pkg.sv
// tds_pkg: shared types and constants for the tick driven job scheduler
// no dependencies; imported by every file under rtl/core
package tds_pkg;

    localparam int JOB_SLOTS_DEF   = 8;
    localparam int TIME_BITS_DEF   = 16;
    localparam int SLOT_BITS_DEF   = $clog2(JOB_SLOTS_DEF);
    localparam int CNT_BITS_DEF    = $clog2(JOB_SLOTS_DEF + 1);

    localparam int ACTION_W        = 2;
    localparam int SLOT_W          = 3;
    localparam int TIME_W          = 16;
    localparam int POLICY_W        = 2;
    localparam int QUANTUM_W       = 8;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 8;

    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REWIND = 2'd2;

    localparam logic [POLICY_W-1:0] POL_FIFO = 2'd0;
    localparam logic [POLICY_W-1:0] POL_SJF  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_STCF = 2'd2;
    localparam logic [POLICY_W-1:0] POL_RR   = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_POLICY  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUANTUM = 1'd1;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_FINISH
    } tds_state_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SLOT_W-1:0]   slot;
        logic [TIME_W-1:0]   arrival_time;
        logic [TIME_W-1:0]   job_duration;
    } tds_in_t;

    typedef struct packed {
        logic [SLOT_W-1:0] running_slot;
        logic              busy_res;
        logic              finished;
        logic              all_done;
        logic [TIME_W-1:0] time_now;
    } tds_out_t;

    // link between neighboring cells, default widths
    typedef struct packed {
        logic                     found;
        logic [TIME_BITS_DEF-1:0] key;
        logic [SLOT_BITS_DEF-1:0] slot;
        logic [TIME_BITS_DEF-1:0] rem;
        logic                     cur_ready;
        logic [TIME_BITS_DEF-1:0] cur_rem;
        logic [CNT_BITS_DEF-1:0]  count;
    } tds_link_t;

    // broadcast from the sequencer to all cells, default widths
    typedef struct packed {
        logic [POLICY_W-1:0]      policy;
        logic [TIME_BITS_DEF-1:0] now;
        logic                     has_cur;
        logic [SLOT_BITS_DEF-1:0] cur_slot;
        logic                     load;
        logic                     rewind;
        logic                     run;
        logic                     requeue;
        logic [SLOT_BITS_DEF-1:0] slot;
        logic [TIME_BITS_DEF-1:0] arrival;
        logic [TIME_BITS_DEF-1:0] duration;
        logic [TIME_BITS_DEF-1:0] requeue_key;
    } tds_bcast_t;

endpackage

// File: rtl/core/tds_cell.sv
// tds_cell: one job slot of the scheduler chain, holds the slot state and
// folds it into the best-candidate link passed on to the next cell; uses tds_pkg
module tds_cell
    import tds_pkg::*;
#(
    parameter int  TIME_BITS = TIME_BITS_DEF,
    parameter int  SLOT_BITS = SLOT_BITS_DEF,
    parameter int  CNT_BITS  = CNT_BITS_DEF,
    parameter int  CELL_ID   = 0,
    parameter type link_t    = tds_link_t,
    parameter type bcast_t   = tds_bcast_t
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  bcast_t bcast,
    input  link_t  link_in,
    output link_t  link_out
);

    logic [TIME_BITS-1:0] arrival_reg;
    logic [TIME_BITS-1:0] loaded_reg;
    logic [TIME_BITS-1:0] remain_reg;
    logic [TIME_BITS-1:0] qkey_reg;
    link_t                link_reg;

    logic [TIME_BITS-1:0] arrival_next;
    logic [TIME_BITS-1:0] loaded_next;
    logic [TIME_BITS-1:0] remain_next;
    logic [TIME_BITS-1:0] qkey_next;
    link_t                link_next;

    logic                 mine;
    logic                 ready;
    logic                 is_cur;
    logic [TIME_BITS-1:0] own_key;

    assign mine   = (bcast.slot == SLOT_BITS'(CELL_ID));
    assign ready  = (arrival_reg <= bcast.now) && (remain_reg != '0);
    assign is_cur = bcast.has_cur && (bcast.cur_slot == SLOT_BITS'(CELL_ID));

    always_comb
    begin
        case (bcast.policy)
            POL_FIFO: own_key = arrival_reg;
            POL_RR:   own_key = qkey_reg;
            default:  own_key = remain_reg;
        endcase
    end

    always_comb
    begin
        link_next = link_in;
        if (ready && (!link_in.found || (own_key < link_in.key)))
        begin
            link_next.found = 1'b1;
            link_next.key   = own_key;
            link_next.slot  = SLOT_BITS'(CELL_ID);
            link_next.rem   = remain_reg;
        end
        if (is_cur && ready)
        begin
            link_next.cur_ready = 1'b1;
            link_next.cur_rem   = remain_reg;
        end
        link_next.count = link_in.count + CNT_BITS'(remain_reg != '0);
    end

    always_comb
    begin
        arrival_next = arrival_reg;
        loaded_next  = loaded_reg;
        remain_next  = remain_reg;
        qkey_next    = qkey_reg;
        if (bcast.load && mine)
        begin
            arrival_next = bcast.arrival;
            loaded_next  = bcast.duration;
            remain_next  = bcast.duration;
            qkey_next    = bcast.arrival;
        end
        else if (bcast.rewind)
        begin
            remain_next = loaded_reg;
            qkey_next   = arrival_reg;
        end
        else if (bcast.run && mine)
        begin
            remain_next = remain_reg - TIME_BITS'(1);
            if (bcast.requeue)
            begin
                qkey_next = bcast.requeue_key;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arrival_reg <= '0;
            loaded_reg  <= '0;
            remain_reg  <= '0;
            qkey_reg    <= '0;
            link_reg    <= '0;
        end
        else
        begin
            arrival_reg <= arrival_next;
            loaded_reg  <= loaded_next;
            remain_reg  <= remain_next;
            qkey_reg    <= qkey_next;
            link_reg    <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

// File: rtl/core/tick_driven_job_scheduler.sv
// tick_driven_job_scheduler: top level, sequencer plus a chain of tds_cell slots
// depends on tds_pkg and tds_cell
//
// usage:
//   request channel: present a request on request and raise start; it is taken
//   at a rising edge where start is high and busy is low. busy stays high
//   while the request is worked on.
//   result channel: one result per request, shown on result for exactly one
//   cycle with done high. the receiver cannot stall, so it must take it then.
//   config port: cfg_we, cfg_index, cfg_data write policy (index 0) or quantum
//   (index 1) at once; write only while busy is low and no result is pending.
// request flow:
//   each request passes through a prep state that applies a load or rewind,
//   a scan state in which the selection ripples down the cell chain, and a
//   finish state that applies the tick; done follows in the next cycle.
//   a new request can be taken in the cycle done is high.
// reset:
//   rst_n clears time, all slots, the current job, policy to fifo and quantum
//   to five.
module tick_driven_job_scheduler
    import tds_pkg::*;
#(
    parameter int JOB_SLOTS = JOB_SLOTS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  tds_in_t                request,
    output logic                   done,
    output tds_out_t               result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SLOT_BITS = $clog2(JOB_SLOTS);
    localparam int CNT_BITS  = $clog2(JOB_SLOTS + 1);
    localparam logic [SLOT_BITS-1:0] LAST_CELL = SLOT_BITS'(JOB_SLOTS - 1);

    typedef struct packed {
        logic                 found;
        logic [TIME_BITS-1:0] key;
        logic [SLOT_BITS-1:0] slot;
        logic [TIME_BITS-1:0] rem;
        logic                 cur_ready;
        logic [TIME_BITS-1:0] cur_rem;
        logic [CNT_BITS-1:0]  count;
    } chain_link_t;

    typedef struct packed {
        logic [POLICY_W-1:0]  policy;
        logic [TIME_BITS-1:0] now;
        logic                 has_cur;
        logic [SLOT_BITS-1:0] cur_slot;
        logic                 load;
        logic                 rewind;
        logic                 run;
        logic                 requeue;
        logic [SLOT_BITS-1:0] slot;
        logic [TIME_BITS-1:0] arrival;
        logic [TIME_BITS-1:0] duration;
        logic [TIME_BITS-1:0] requeue_key;
    } chain_bcast_t;

    tds_state_t           state_reg,    state_next;
    logic [SLOT_BITS-1:0] scan_cnt_reg, scan_cnt_next;
    tds_in_t              req_reg,      req_next;
    logic [TIME_W-1:0]    time_reg,     time_next;
    logic [TIME_BITS-1:0] clock_reg,    clock_next;
    logic [SLOT_BITS-1:0] cur_slot_reg, cur_slot_next;
    logic                 has_cur_reg,  has_cur_next;
    logic [QUANTUM_W-1:0] slice_reg,    slice_next;
    logic                 done_reg,     done_next;
    tds_out_t             result_reg,   result_next;
    logic [POLICY_W-1:0]  policy_reg;
    logic [QUANTUM_W-1:0] quantum_reg;

    chain_bcast_t         bcast;
    chain_link_t          links [JOB_SLOTS+1];
    chain_link_t          tail;

    logic [SLOT_BITS-1:0] load_slot;
    logic                 load_ok;
    logic [QUANTUM_W-1:0] q_eff;
    logic                 keep;
    logic                 chosen_ok;
    logic [SLOT_BITS-1:0] chosen;
    logic [TIME_BITS-1:0] chosen_rem;
    logic [QUANTUM_W-1:0] slice_new;
    logic                 fin;
    logic [TIME_BITS-1:0] time_inc;

    assign links[0] = '0;
    assign tail     = links[JOB_SLOTS];

    genvar gi;
    generate
        for (gi = 0; gi < JOB_SLOTS; gi++)
        begin : g_cell
            tds_cell #(
                .TIME_BITS (TIME_BITS),
                .SLOT_BITS (SLOT_BITS),
                .CNT_BITS  (CNT_BITS),
                .CELL_ID   (gi),
                .link_t    (chain_link_t),
                .bcast_t   (chain_bcast_t)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .bcast    (bcast),
                .link_in  (links[gi]),
                .link_out (links[gi+1])
            );
        end
    endgenerate

    assign load_slot = SLOT_BITS'(req_reg.slot);
    assign load_ok   = (int'(req_reg.slot) < JOB_SLOTS);
    assign q_eff     = (quantum_reg == '0) ? QUANTUM_W'(1) : quantum_reg;
    assign keep      = has_cur_reg && tail.cur_ready &&
                       ((policy_reg == POL_FIFO) || (policy_reg == POL_SJF) ||
                        ((policy_reg == POL_RR) && (slice_reg < q_eff)));
    assign chosen_ok  = keep || tail.found;
    assign chosen     = keep ? cur_slot_reg : tail.slot;
    assign chosen_rem = keep ? tail.cur_rem : tail.rem;
    assign slice_new  = (keep ? slice_reg : '0) + QUANTUM_W'(1);
    assign fin        = chosen_ok && (chosen_rem == TIME_BITS'(1));
    assign time_inc   = (clock_reg != '1) ? clock_reg + TIME_BITS'(1) : clock_reg;

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        req_next      = req_reg;
        time_next     = time_reg;
        clock_next    = clock_reg;
        cur_slot_next = cur_slot_reg;
        has_cur_next  = has_cur_reg;
        slice_next    = slice_reg;
        done_next     = 1'b0;
        result_next   = result_reg;

        bcast             = '0;
        bcast.policy      = policy_reg;
        bcast.now         = clock_reg;
        bcast.has_cur     = has_cur_reg;
        bcast.cur_slot    = cur_slot_reg;
        bcast.slot        = load_slot;
        bcast.arrival     = TIME_BITS'(req_reg.arrival_time);
        bcast.duration    = TIME_BITS'(req_reg.job_duration);
        bcast.requeue_key = time_inc;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    time_next  = TIME_W'(clock_reg);
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                case (req_reg.action)
                    ACT_LOAD:
                    begin
                        if (load_ok)
                        begin
                            bcast.load = 1'b1;
                            if (has_cur_reg && (cur_slot_reg == load_slot))
                            begin
                                has_cur_next = 1'b0;
                                slice_next   = '0;
                            end
                        end
                    end
                    ACT_REWIND:
                    begin
                        bcast.rewind = 1'b1;
                        clock_next   = '0;
                        has_cur_next = 1'b0;
                        slice_next   = '0;
                    end
                    default:
                    begin
                    end
                endcase
                scan_cnt_next = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == LAST_CELL)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + SLOT_BITS'(1);
                end
            end
            ST_FINISH:
            begin
                done_next                = 1'b1;
                result_next.running_slot = '0;
                result_next.busy_res     = 1'b0;
                result_next.finished     = 1'b0;
                result_next.all_done     = (tail.count == '0);
                result_next.time_now     = time_reg;
                if (req_reg.action == ACT_TICK)
                begin
                    clock_next = time_inc;
                    if (chosen_ok)
                    begin
                        bcast.run                = 1'b1;
                        bcast.slot               = chosen;
                        result_next.running_slot = SLOT_W'(chosen);
                        result_next.busy_res     = 1'b1;
                        result_next.finished     = fin;
                        result_next.all_done     =
                            (tail.count == (fin ? CNT_BITS'(1) : CNT_BITS'(0)));
                        cur_slot_next = chosen;
                        if (fin)
                        begin
                            has_cur_next = 1'b0;
                            slice_next   = '0;
                        end
                        else if ((policy_reg == POL_RR) && (slice_new >= q_eff))
                        begin
                            bcast.requeue = 1'b1;
                            has_cur_next  = 1'b0;
                            slice_next    = '0;
                        end
                        else
                        begin
                            has_cur_next = 1'b1;
                            slice_next   = slice_new;
                        end
                    end
                    else
                    begin
                        has_cur_next = 1'b0;
                        slice_next   = '0;
                    end
                end
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            clock_reg    <= '0;
            cur_slot_reg <= '0;
            has_cur_reg  <= 1'b0;
            slice_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            clock_reg    <= clock_next;
            cur_slot_reg <= cur_slot_next;
            has_cur_reg  <= has_cur_next;
            slice_reg    <= slice_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        time_reg   <= time_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg  <= POL_FIFO;
            quantum_reg <= QUANTUM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLICY:  policy_reg  <= cfg_data[POLICY_W-1:0];
                CFG_QUANTUM: quantum_reg <= cfg_data[QUANTUM_W-1:0];
            endcase
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/core/tds_checker.sv
// tds_checker: port-level checks for tick_driven_job_scheduler, bound to the top
// depends on tds_pkg and tick_driven_job_scheduler
module tds_checker
    import tds_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input tds_out_t result
);

    // accepted request keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but busy not raised");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.busy_res |-> (result.running_slot == '0) && !result.finished)
        else $error("idle result carries a slot or finish flag");

    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy raised without a request");

endmodule

bind tick_driven_job_scheduler tds_checker u_tds_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// File: verif/tds_schedule_checker.sv
// tds_schedule_checker: watches the request, result and register ports of the scheduler,
// predicts each result from its own copy of slot and time state and compares field by field
// depends on tds_pkg
module tds_schedule_checker
    import tds_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  tds_in_t                request,
    input  logic                   done,
    input  tds_out_t               result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     outstanding
);

    localparam int SLOTS = JOB_SLOTS_DEF;

    logic [POLICY_W-1:0]  sched_policy;
    logic [QUANTUM_W-1:0] slice_limit;
    logic [TIME_W-1:0]    tick_count;
    logic [TIME_W-1:0]    arrive_at  [SLOTS];
    logic [TIME_W-1:0]    job_len    [SLOTS];
    logic [TIME_W-1:0]    work_left  [SLOTS];
    logic [TIME_W-1:0]    queue_rank [SLOTS];
    logic [SLOT_W-1:0]    active_slot;
    logic                 active_valid;
    logic [QUANTUM_W-1:0] slice_count;

    tds_out_t expected_results [$];
    tds_out_t oldest;

    function automatic void enqueue_expected(tds_out_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic bit slot_ready(int s, logic [TIME_W-1:0] t);
        return arrive_at[s] <= t && work_left[s] != '0;
    endfunction

    function automatic logic [TIME_W-1:0] rank_of(int s);
        if (sched_policy == POL_FIFO)
            return arrive_at[s];
        if (sched_policy == POL_RR)
            return queue_rank[s];
        return work_left[s];
    endfunction

    function automatic int best_ready(logic [TIME_W-1:0] t);
        int best;
        logic [TIME_W-1:0] best_rank;
        best = -1;
        best_rank = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (slot_ready(s, t) && (best < 0 || rank_of(s) < best_rank))
            begin
                best = s;
                best_rank = rank_of(s);
            end
        end
        return best;
    endfunction

    function automatic tds_out_t schedule_request(tds_in_t req);
        tds_out_t res;
        logic [TIME_W-1:0] t;
        logic [QUANTUM_W-1:0] q;
        bit keep;
        int pick;
        res = '0;
        t = tick_count;
        res.time_now = t;
        case (req.action)
            ACT_LOAD:
            begin
                arrive_at[req.slot] = req.arrival_time;
                job_len[req.slot] = req.job_duration;
                work_left[req.slot] = req.job_duration;
                queue_rank[req.slot] = req.arrival_time;
                if (active_valid && active_slot == req.slot)
                begin
                    active_valid = 1'b0;
                    slice_count = '0;
                end
            end
            ACT_REWIND:
            begin
                tick_count = '0;
                for (int s = 0; s < SLOTS; s++)
                begin
                    work_left[s] = job_len[s];
                    queue_rank[s] = arrive_at[s];
                end
                active_valid = 1'b0;
                slice_count = '0;
            end
            ACT_TICK:
            begin
                q = (slice_limit == '0) ? QUANTUM_W'(1) : slice_limit;
                keep = 1'b0;
                if (active_valid && slot_ready(int'(active_slot), t))
                begin
                    if (sched_policy == POL_FIFO || sched_policy == POL_SJF)
                        keep = 1'b1;
                    else if (sched_policy == POL_RR && slice_count < q)
                        keep = 1'b1;
                end
                if (keep)
                    pick = int'(active_slot);
                else
                begin
                    pick = best_ready(t);
                    slice_count = '0;
                end
                if (pick >= 0)
                begin
                    res.busy_res = 1'b1;
                    res.running_slot = pick[SLOT_W-1:0];
                    work_left[pick] = work_left[pick] - TIME_W'(1);
                    active_slot = pick[SLOT_W-1:0];
                    active_valid = 1'b1;
                    slice_count = slice_count + QUANTUM_W'(1);
                    if (work_left[pick] == '0)
                    begin
                        res.finished = 1'b1;
                        active_valid = 1'b0;
                        slice_count = '0;
                    end
                    else if (sched_policy == POL_RR && slice_count >= q)
                    begin
                        // expired slice goes behind everything already waiting
                        queue_rank[pick] = (t != '1) ? t + TIME_W'(1) : t;
                        active_valid = 1'b0;
                        slice_count = '0;
                    end
                end
                else
                begin
                    active_valid = 1'b0;
                    slice_count = '0;
                end
                if (tick_count != '1)
                    tick_count = tick_count + TIME_W'(1);
            end
            default:
            begin
            end
        endcase
        res.all_done = 1'b1;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (work_left[s] != '0)
                res.all_done = 1'b0;
        end
        return res;
    endfunction

    task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_policy = POL_FIFO;
            slice_limit = QUANTUM_RESET;
            tick_count = '0;
            for (int s = 0; s < SLOTS; s++)
            begin
                arrive_at[s] = '0;
                job_len[s] = '0;
                work_left[s] = '0;
                queue_rank[s] = '0;
            end
            active_slot = '0;
            active_valid = 1'b0;
            slice_count = '0;
            expected_results.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POLICY:  sched_policy = cfg_data[POLICY_W-1:0];
                    CFG_QUANTUM: slice_limit = cfg_data[QUANTUM_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request waiting");
                    mismatches++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    compare_field("running_slot", 32'(oldest.running_slot),
                                  32'(result.running_slot));
                    compare_field("busy_res", 32'(oldest.busy_res), 32'(result.busy_res));
                    compare_field("finished", 32'(oldest.finished), 32'(result.finished));
                    compare_field("all_done", 32'(oldest.all_done), 32'(result.all_done));
                    compare_field("time_now", 32'(oldest.time_now), 32'(result.time_now));
                end
            end
            if (start && !busy)
                enqueue_expected(schedule_request(request));
            outstanding = expected_results.size();
        end
    end

endmodule

// File: verif/tick_driven_job_scheduler_test.sv
// tick_driven_job_scheduler_test: drives load, tick, rewind and unused-action requests and register writes
// into the scheduler across all policies and idle patterns, then gives the verdict
// depends on tds_pkg, tick_driven_job_scheduler and tds_schedule_checker
module tick_driven_job_scheduler_test;
    import tds_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = JOB_SLOTS_DEF + 4;
    localparam int PHASE_ITEMS    = 32;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    tds_in_t                request = '0;
    logic                   done;
    tds_out_t               result;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int mismatches;
    int outstanding;
    int requests_sent = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int idle_pct = 0;

    tick_driven_job_scheduler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tds_schedule_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (done)
            results_seen <= results_seen + 1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic tds_in_t make_request(logic [ACTION_W-1:0] action, int slot,
                                             int arrival, int duration);
        tds_in_t r;
        r.action = action;
        r.slot = slot[SLOT_W-1:0];
        r.arrival_time = arrival[TIME_W-1:0];
        r.job_duration = duration[TIME_W-1:0];
        return r;
    endfunction

    // tick and rewind carry junk in the unused fields
    function automatic tds_in_t control_request(logic [ACTION_W-1:0] action);
        return make_request(action, $urandom_range(7), $urandom_range(65535),
                            $urandom_range(65535));
    endfunction

    task automatic send(input tds_in_t r);
        int gap;
        gap = 0;
        request <= r;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        requests_sent++;
        if ($urandom_range(99) < idle_pct)
            gap = $urandom_range(1, 24);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (results_seen != requests_sent)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [POLICY_W-1:0] policy, input int quantum);
        settle();
        write_reg(CFG_POLICY, int'(policy));
        write_reg(CFG_QUANTUM, quantum);
    endtask

    task automatic random_load();
        send(make_request(ACT_LOAD, $urandom_range(7), $urandom_range(12),
                          ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8)));
    endtask

    task automatic random_phase(input logic [POLICY_W-1:0] policy, input int quantum,
                                input int pct);
        int goal;
        int ticks;
        logic [63:0] noise;
        tds_in_t junk;
        configure(policy, quantum);
        idle_pct = pct;
        goal = requests_sent + PHASE_ITEMS;
        while (requests_sent < goal)
        begin
            if ($urandom_range(99) < 8)
            begin
                noise = {$urandom, $urandom};
                junk = noise[$bits(tds_in_t)-1:0];
                send(junk);
            end
            else
            begin
                if ($urandom_range(2) == 0)
                    send(control_request(ACT_REWIND));
                repeat ($urandom_range(1, 4)) random_load();
                ticks = $urandom_range(4, 24);
                repeat (ticks)
                begin
                    if ($urandom_range(9) == 0)
                        random_load();
                    send(control_request(ACT_TICK));
                end
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty tick, unused action, field extremes, reload of running slot
        send(control_request(ACT_TICK));
        send(make_request(ACT_UNUSED, 7, 65535, 65535));
        send(make_request(ACT_LOAD, 0, 0, 2));
        send(make_request(ACT_LOAD, 7, 65535, 65535));
        send(make_request(ACT_LOAD, 3, 1, 1));
        send(make_request(ACT_LOAD, 5, 0, 0));
        send(control_request(ACT_TICK));
        send(make_request(ACT_LOAD, 0, 0, 3));
        repeat (4) send(control_request(ACT_TICK));
        send(make_request(ACT_LOAD, 7, 0, 0));
        send(control_request(ACT_REWIND));
        repeat (5) send(control_request(ACT_TICK));

        random_phase(POL_FIFO, 5, 0);
        random_phase(POL_SJF, 5, 75);
        random_phase(POL_STCF, 1, 18);
        random_phase(POL_RR, 1, 0);
        random_phase(POL_RR, 0, 75);
        random_phase(POL_RR, 255, 18);
        random_phase(POL_RR, 3, 0);
        random_phase(POL_SJF, 2, 75);
        random_phase(POL_FIFO, 7, 18);

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
